// ===== sv/fra_pkg.sv =====
// Shared types, codes and constants of the fenced ring buffer allocator.
package fra_pkg;

  // Fence queue depth and allocation granule (granule is a power of two).
  localparam int FENCE_DEPTH = 16;
  localparam int ALIGN_LOG2  = 8;
  localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;

  localparam int PTR_W  = $clog2(FENCE_DEPTH);
  localparam int CNT_W  = $clog2(FENCE_DEPTH + 1);
  localparam int SIZE_W = 34;

  localparam logic [SIZE_W-1:0] ALIGN_MASK   = SIZE_W'(ALIGN_BYTES - 1);
  localparam logic [32:0]       MAX_SIZE_RST = 33'd1048576;

  // Item kinds.
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_QFULL   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [32:0] request_size;
    logic [47:0] fence_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [32:0] granted_size;
    logic [32:0] used_bytes;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic alloc_prep;
    logic alloc_exec;
    logic close_exec;
    logic rel_pop;
    logic plain_result;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/fra_ctl.sv =====
// Sequencing state machine of the fenced ring buffer allocator.
module fra_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_stall,
  output fra_pkg::ctl_cmd_t cmd,
  input  fra_pkg::dp_status_t st
);
  import fra_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_ALLOC_PREP = 7'b0000010,
    S_ALLOC_EXEC = 7'b0000100,
    S_CLOSE      = 7'b0001000,
    S_REL_LOAD   = 7'b0010000,
    S_REL_POP    = 7'b0100000,
    S_NOP        = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Items are taken only between operations.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            KIND_ALLOC:   state_nxt = S_ALLOC_PREP;
            KIND_CLOSE:   state_nxt = S_CLOSE;
            KIND_RELEASE: state_nxt = S_REL_LOAD;
            default:      state_nxt = S_NOP;
          endcase
        end
      end
      S_ALLOC_PREP: begin
        cmd.alloc_prep = 1'b1;
        state_nxt      = S_ALLOC_EXEC;
      end
      S_ALLOC_EXEC: begin
        if (st.out_free) begin
          cmd.alloc_exec = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (st.out_free) begin
          cmd.close_exec = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_REL_LOAD: begin
        state_nxt = S_REL_POP;
      end
      S_REL_POP: begin
        priority if (st.pop_ok) begin
          cmd.rel_pop = 1'b1;
        end else if (st.out_free) begin
          cmd.plain_result = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_NOP: begin
        if (st.out_free) begin
          cmd.plain_result = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/fra_dp.sv =====
// Ring pointers, fence queue and result register of the allocator.
module fra_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fra_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  logic [32:0]         cfg_data,
  input  fra_pkg::ctl_cmd_t   cmd,
  output fra_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_stall,
  output fra_pkg::out_item_t  out_item
);
  import fra_pkg::*;

  typedef struct packed {
    logic [47:0] fence;
    logic [32:0] tail;
    logic [32:0] bytes;
  } q_entry_t;

  // Architectural state.
  logic [32:0]      max_r;
  logic [32:0]      head_r, head_nxt;
  logic [32:0]      tail_r, tail_nxt;
  logic [32:0]      used_r, used_nxt;
  logic [32:0]      pend_r, pend_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt, rd_inc;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_inc;
  logic [CNT_W-1:0] q_count_r, q_count_nxt;

  // Working registers of the current item.
  in_item_t          item_r;
  logic [SIZE_W-1:0] size_r;
  logic [32:0]       avail_r;
  logic [32:0]       skip_r;
  logic              full_r;
  logic              tge_r;

  // Fence queue storage.
  q_entry_t         q_mem [FENCE_DEPTH];
  q_entry_t         rd_data_r;
  logic [PTR_W-1:0] rd_addr;
  logic             q_we;

  // Result register.
  logic       out_valid_r;
  out_item_t  out_item_r, result;
  logic       result_we;

  // Allocation decision terms.
  logic [SIZE_W-1:0] size_round;
  logic [34:0]       end_sum;
  logic              room_ok, fit_end, fit_head, fit_gap;
  logic              q_full;

  assign st.out_free = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_item    = out_item_r;

  assign rd_inc = (rd_ptr_r == PTR_W'(FENCE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc = (wr_ptr_r == PTR_W'(FENCE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign q_full = (q_count_r >= CNT_W'(FENCE_DEPTH));

  // The oldest entry may be popped when its fence has completed.
  assign st.pop_ok = (q_count_r != '0) && (rd_data_r.fence <= item_r.fence_value);

  // Request rounded up to the granule at full precision.
  assign size_round = ({1'b0, item_r.request_size} + ALIGN_MASK) & ~ALIGN_MASK;

  // Fit checks against the prepared terms.
  assign room_ok  = !full_r && ({1'b0, avail_r} >= size_r);
  assign end_sum  = {2'b00, tail_r} + {1'b0, size_r};
  assign fit_end  = end_sum <= {2'b00, max_r};
  assign fit_head = size_r <= {1'b0, head_r};
  assign fit_gap  = end_sum <= {2'b00, head_r};

  assign q_we    = cmd.close_exec && (item_r.kind == KIND_CLOSE) && !q_full;
  assign rd_addr = (cmd.rel_pop && st.pop_ok) ? rd_inc : rd_ptr_r;

  // Next state of the ring and the result of the finishing step.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    used_nxt    = used_r;
    pend_nxt    = pend_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    q_count_nxt = q_count_r;
    result_we   = 1'b0;
    result      = '0;

    if (cmd.alloc_exec) begin
      result_we           = 1'b1;
      result.granted_size = size_r[32:0];
      result.status       = STATUS_REFUSED;
      if (room_ok) begin
        if ((tge_r && fit_end) || (!tge_r && fit_gap)) begin
          // Grant right after the tail.
          result.status = STATUS_OK;
          result.offset = tail_r[31:0];
          tail_nxt      = end_sum[32:0];
          used_nxt      = used_r + size_r[32:0];
          pend_nxt      = pend_r + size_r[32:0];
        end else if (tge_r && fit_head) begin
          // Wrap to the start; the skipped end bytes count as used.
          result.status = STATUS_OK;
          tail_nxt      = size_r[32:0];
          used_nxt      = used_r + skip_r + size_r[32:0];
          pend_nxt      = pend_r + skip_r + size_r[32:0];
        end
      end
      result.used_bytes = used_nxt;
    end

    if (cmd.close_exec) begin
      result_we = 1'b1;
      if (item_r.kind == KIND_CLOSE) begin
        if (q_full) begin
          result.status = STATUS_QFULL;
        end else begin
          wr_ptr_nxt  = wr_inc;
          q_count_nxt = q_count_r + 1'b1;
          pend_nxt    = '0;
        end
      end
      result.used_bytes = used_r;
    end

    if (cmd.rel_pop && st.pop_ok) begin
      used_nxt    = (rd_data_r.bytes <= used_r) ? used_r - rd_data_r.bytes : '0;
      head_nxt    = rd_data_r.tail;
      rd_ptr_nxt  = rd_inc;
      q_count_nxt = q_count_r - 1'b1;
    end

    if (cmd.plain_result) begin
      result_we         = 1'b1;
      result.used_bytes = used_r;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_SIZE_RST;
      head_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      pend_r      <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      q_count_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      used_r    <= used_nxt;
      pend_r    <= pend_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      q_count_r <= q_count_nxt;
      if (result_we) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture, allocation preparation and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.alloc_prep) begin
      size_r  <= size_round;
      avail_r <= max_r - used_r;
      full_r  <= used_r >= max_r;
      skip_r  <= (max_r > tail_r) ? max_r - tail_r : '0;
      tge_r   <= tail_r >= head_r;
    end
    if (result_we) begin
      out_item_r <= result;
    end
  end

  // Fence queue memory with registered read.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[wr_ptr_r] <= '{fence: item_r.fence_value, tail: tail_r, bytes: pend_r};
    end
    rd_data_r <= q_mem[rd_addr];
  end

  // The queue never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= CNT_W'(FENCE_DEPTH))
    else $error("fence queue count beyond depth");

  // A pop removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rel_pop && st.pop_ok) |=> (q_count_r == $past(q_count_r) - 1'b1))
    else $error("pop did not lower the queue count by one");

  // An accepted close adds exactly one entry and clears the pending bytes.
  a_close_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_we |=> (q_count_r == $past(q_count_r) + 1'b1) && (pend_r == '0))
    else $error("close did not push one entry");

  // A result is never written over one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result_we |-> st.out_free)
    else $error("result written while output held");

endmodule

// ===== sv/fenced_ring_buffer_allocator.sv =====
// Top level of the fenced ring buffer allocator: controller plus datapath.
//
// The block hands out 256-byte aligned space from a ring of max_size bytes
// and tracks it per fence in a 16-entry queue. One item is worked on at a
// time, and each item gives exactly one result. An allocate is captured, its
// size rounded and fit terms prepared, then the grant writes its result. A
// close or an unused kind is captured and then writes its result. A release
// is captured, then frees entries one per cycle while the oldest fence has
// completed, since the fence queue memory is read one entry per cycle, then
// writes its result. The next item is accepted in the cycle after the result
// is written into the output register, so a held result stalls the input
// only when a second result is ready behind it. No clearing pass runs after
// reset; max_size resets to 1 MiB and may be rewritten while idle.
module fenced_ring_buffer_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fra_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output fra_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [32:0]        cfg_data
);
  import fra_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  // Sequencer.
  fra_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_item.kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  // Ring state, fence queue and output register.
  fra_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== dv/tb_fenced_ring_buffer_allocator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the fenced ring buffer allocator with a ring predictor.
module tb_fenced_ring_buffer_allocator;
  import fra_pkg::*;

  localparam int          HOLD_CYCLES   = 300;
  localparam int          QUIET_LIMIT   = 3000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          PHASES        = 6;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam logic [47:0] FENCE_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [32:0] SIZE_TOP      = 33'h1_0000_0000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_PRESSURE} idle_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [32:0] cfg_data  = '0;

  fenced_ring_buffer_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be offered and results waiting to arrive.
  in_item_t   item_backlog[$];
  out_item_t  awaited_results[$];
  idle_mode_t idle_mode    = IDLE_NONE;
  int         hold_cnt     = 0;
  int         quiet_cycles = 0;
  int         err_count    = 0;

  // Fence numbers used by the well-formed close and release sequences.
  logic [47:0] next_fence     = 48'd100;
  logic [47:0] released_fence = 48'd100;

  // Settings of the random phases.
  logic [32:0] phase_cap [PHASES] = '{33'd256, 33'd4096, SIZE_TOP, 33'd65536,
                                      33'd1048576, 33'd8192};
  idle_mode_t  phase_mode [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                       IDLE_PRESSURE, IDLE_NONE};
  int          phase_len [PHASES] = '{100, 200, 200, 200, 150, 150};

  // Predicted ring and fence queue state.
  logic [32:0]      ring_cap     = MAX_SIZE_RST;
  logic [32:0]      ring_head    = '0;
  logic [32:0]      ring_tail    = '0;
  logic [32:0]      ring_used    = '0;
  logic [32:0]      ring_pending = '0;
  logic [47:0]      fq_fence [FENCE_DEPTH];
  logic [32:0]      fq_tail  [FENCE_DEPTH];
  logic [32:0]      fq_bytes [FENCE_DEPTH];
  logic [PTR_W-1:0] fq_rd    = '0;
  int               fq_count = 0;

  // Apply one item to the predicted state and return the result it gives.
  function automatic out_item_t next_result(in_item_t it);
    out_item_t        r;
    logic [34:0]      rsize;
    logic [32:0]      skip;
    logic [32:0]      amount;
    logic [PTR_W-1:0] wr;
    logic             fits_tail;
    logic             fits_wrap;
    r = '0;
    case (it.kind)
      KIND_ALLOC: begin
        rsize = ((35'(it.request_size) + 35'(ALIGN_BYTES - 1)) >> ALIGN_LOG2) << ALIGN_LOG2;
        r.granted_size = rsize[32:0];
        r.status = STATUS_REFUSED;
        fits_tail = 1'b0;
        fits_wrap = 1'b0;
        // Full ring and short free space refuse before any placement.
        if (ring_used < ring_cap && 35'(ring_cap - ring_used) >= rsize) begin
          if (ring_tail >= ring_head) begin
            fits_tail = (35'(ring_tail) + rsize) <= 35'(ring_cap);
            fits_wrap = !fits_tail && rsize <= 35'(ring_head);
          end else begin
            fits_tail = (35'(ring_tail) + rsize) <= 35'(ring_head);
          end
        end
        if (fits_tail) begin
          r.status     = STATUS_OK;
          r.offset     = ring_tail[31:0];
          ring_tail    = ring_tail + rsize[32:0];
          ring_used    = ring_used + rsize[32:0];
          ring_pending = ring_pending + rsize[32:0];
        end else if (fits_wrap) begin
          // The bytes skipped at the end of the ring are charged as used.
          skip         = (ring_cap > ring_tail) ? ring_cap - ring_tail : '0;
          amount       = skip + rsize[32:0];
          r.status     = STATUS_OK;
          ring_used    = ring_used + amount;
          ring_pending = ring_pending + amount;
          ring_tail    = rsize[32:0];
        end
      end
      KIND_CLOSE: begin
        if (fq_count >= FENCE_DEPTH) begin
          r.status = STATUS_QFULL;
        end else begin
          wr           = fq_rd + PTR_W'(fq_count);
          fq_fence[wr] = it.fence_value;
          fq_tail[wr]  = ring_tail;
          fq_bytes[wr] = ring_pending;
          fq_count     = fq_count + 1;
          ring_pending = '0;
        end
      end
      KIND_RELEASE: begin
        while (fq_count > 0 && fq_fence[fq_rd] <= it.fence_value) begin
          ring_used = (fq_bytes[fq_rd] <= ring_used) ? ring_used - fq_bytes[fq_rd] : '0;
          ring_head = fq_tail[fq_rd];
          fq_rd     = fq_rd + 1'b1;
          fq_count  = fq_count - 1;
        end
      end
      default: begin
      end
    endcase
    r.used_bytes = ring_used;
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] kind, logic [32:0] size, logic [47:0] fence);
    in_item_t it;
    it.kind         = kind;
    it.request_size = size;
    it.fence_value  = fence;
    return it;
  endfunction

  function automatic logic [47:0] rand_fence();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Any request size that fits in 32 bits, or SIZE_TOP.
  function automatic logic [32:0] rand_request();
    if ($urandom_range(9, 0) == 0) begin
      return SIZE_TOP;
    end
    return {1'b0, 32'($urandom())};
  endfunction

  // Sizes mostly scaled to the ring so that fills, wraps and refusals all occur.
  function automatic logic [32:0] pick_size(logic [32:0] cap);
    int unsigned lim;
    int unsigned roll;
    lim  = (cap > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : cap[31:0];
    roll = $urandom_range(99, 0);
    if (roll < 70) begin
      return 33'($urandom_range(lim >> 3, 0));
    end else if (roll < 92) begin
      return 33'($urandom_range(lim, 0));
    end
    return rand_request();
  endfunction

  function automatic logic sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99, 0) < 81;
      IDLE_BOTH: return $urandom_range(99, 0) < 25;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_holds();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99, 0) < 81;
      IDLE_BOTH: return $urandom_range(99, 0) < 25;
      default:   return 1'b0;
    endcase
  endfunction

  // Mostly well-formed allocate, close and release runs, with some noise items.
  task automatic add_random_items(int n, logic [32:0] cap);
    int          added;
    int          burst;
    logic [47:0] span;
    logic [1:0]  kind;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99, 0) < 80) begin
        burst = $urandom_range(4, 1);
        repeat (burst) item_backlog.push_back(mk_item(KIND_ALLOC, pick_size(cap), rand_fence()));
        next_fence = next_fence + 48'($urandom_range(3, 1));
        item_backlog.push_back(mk_item(KIND_CLOSE, rand_request(), next_fence));
        added = added + burst + 1;
        if ($urandom_range(99, 0) < 60) begin
          span           = next_fence - released_fence;
          released_fence = released_fence + 48'($urandom_range(32'(span), 0));
          item_backlog.push_back(mk_item(KIND_RELEASE, rand_request(), released_fence));
          added = added + 1;
        end
      end else begin
        kind = ($urandom_range(19, 0) == 0) ? KIND_UNUSED : 2'($urandom_range(2, 0));
        item_backlog.push_back(mk_item(kind, rand_request(), rand_fence()));
        added = added + 1;
      end
    end
  endtask

  // Wait until every item has been taken and every result has come back.
  task automatic drain();
    while (item_backlog.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ring_cap(logic [32:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    ring_cap = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Item driver: predicts each item as it is accepted, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(next_result(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() != 0 && !sender_rests()) begin
          in_item  <= item_backlog[0];
          in_valid <= 1'b1;
          item_backlog.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: one long hold-off in the pressure phase, random stalls otherwise.
  always @(posedge clk) begin
    if (idle_mode == IDLE_PRESSURE && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= receiver_holds();
    end
  end

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endfunction

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: %p", out_item);
        err_count++;
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        check_field("status", 48'(want.status), 48'(out_item.status));
        check_field("offset", 48'(want.offset), 48'(out_item.offset));
        check_field("granted_size", 48'(want.granted_size), 48'(out_item.granted_size));
        check_field("used_bytes", 48'(want.used_bytes), 48'(out_item.used_bytes));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_fenced_ring_buffer_allocator failed");
      $finish;
    end
  end

  // Test sequence: directed items at the reset ring size, then random phases.
  initial begin : sequencer
    int ph;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Zero size, rounding from the bottom and the top of a granule, and an oversized request.
    item_backlog.push_back(mk_item(KIND_ALLOC, 33'd0, 48'd0));
    item_backlog.push_back(mk_item(KIND_ALLOC, 33'd1, FENCE_MAX));
    item_backlog.push_back(mk_item(KIND_ALLOC, 33'd255, 48'd0));
    item_backlog.push_back(mk_item(KIND_ALLOC, SIZE_TOP, 48'd0));
    // A release below the queued fence frees nothing; one at the top frees it.
    item_backlog.push_back(mk_item(KIND_CLOSE, 33'h1_FFFF_FFFF, FENCE_MAX));
    item_backlog.push_back(mk_item(KIND_RELEASE, 33'd0, 48'd0));
    item_backlog.push_back(mk_item(KIND_RELEASE, SIZE_TOP, FENCE_MAX));
    item_backlog.push_back(mk_item(KIND_UNUSED, SIZE_TOP, FENCE_MAX));
    // Fill the fence queue and close once more while it is full.
    for (n = 1; n <= FENCE_DEPTH + 1; n++) begin
      item_backlog.push_back(mk_item(KIND_CLOSE, 33'd0, 48'(n)));
    end
    // Bytes allocated now stay pending past the refused close.
    item_backlog.push_back(mk_item(KIND_ALLOC, 33'd256, 48'd0));
    item_backlog.push_back(mk_item(KIND_RELEASE, 33'd0, FENCE_MAX));
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      write_ring_cap(phase_cap[ph]);
      idle_mode = phase_mode[ph];
      add_random_items(phase_len[ph], phase_cap[ph]);
      drain();
    end

    if (err_count == 0) begin
      $display("tb_fenced_ring_buffer_allocator passed");
    end else begin
      $display("tb_fenced_ring_buffer_allocator failed");
    end
    $finish;
  end

endmodule
